[rtl/assert_macros.svh]
// Assertion macros shared by the RTL; define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/segi_pkg.sv]
// Widths, constants and types for the segment intersection pipeline.
package segi_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int CROSS_W    = PROD_W + 1;
  localparam int MUL_W      = CROSS_W + DIFF_W;
  localparam int RND_SHIFT  = 17;
  localparam int QBITS      = 41;
  localparam int DVD_RAW    = MUL_W + RND_SHIFT + 1;
  localparam int DVD_W      = (DVD_RAW > QBITS + 1) ? DVD_RAW : QBITS + 1;
  localparam int REM_W      = CROSS_W + 1;
  localparam int SUM_W      = 43;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_W      = 32;

  localparam logic [QBITS-1:0] OFF_LIM = QBITS'(1) << (QBITS - 1);
  localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'(64'sh7FFF_FFFF);
  localparam logic signed [SUM_W-1:0] OUT_MIN = -SUM_W'(64'sh8000_0000);

  typedef struct packed {
    logic [REM_W-1:0]             rem_x;
    logic [REM_W-1:0]             rem_y;
    logic [QBITS-1:0]             q_x;
    logic [QBITS-1:0]             q_y;
    logic [REM_W-1:0]             dd;
    logic                         hit;
    logic                         neg_x;
    logic                         neg_y;
    logic                         ovf_x;
    logic                         ovf_y;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
  } div_stage_t;

endpackage

[rtl/segment_intersection_top.sv]
// Pipelined two-segment intersection with Q16.16 rounded meeting point.
//
//  channel   | handshake        | payload
//  ----------+------------------+------------------------------------------
//  input     | start / busy     | a_start_x .. b_end_y (signed coordinates)
//  result    | done (one cycle) | hit, inter_x, inter_y (signed Q16.16)
//  config    | cfg_we           | cfg_wdata (infinite_lines_mode)
//
// One pair enters per cycle. The restoring divider produces one quotient bit per stage
// over 41 stages, behind eight stages of differences, cross products and setup.
// busy stays low: the pipeline never stalls, since results cannot be held off.
// Reset clears the valid bits and the mode register only.
`include "assert_macros.svh"

module segment_intersection_top
  import segi_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] a_start_x,
  input  logic signed [COORD_BITS-1:0] a_start_y,
  input  logic signed [COORD_BITS-1:0] a_end_x,
  input  logic signed [COORD_BITS-1:0] a_end_y,
  input  logic signed [COORD_BITS-1:0] b_start_x,
  input  logic signed [COORD_BITS-1:0] b_start_y,
  input  logic signed [COORD_BITS-1:0] b_end_x,
  input  logic signed [COORD_BITS-1:0] b_end_y,
  input  logic                         cfg_we,
  input  logic                         cfg_wdata,
  output logic                         done,
  output logic                         hit,
  output logic signed [OUT_W-1:0]      inter_x,
  output logic signed [OUT_W-1:0]      inter_y
);

  logic infinite_lines_mode;
  logic v1, v2, v3, v4, v5, v6, v7, v50;

  // stage 1 registers: directions and offset
  logic signed [DIFF_W-1:0] d1x1, d1y1, d2x1, d2y1, wx1, wy1;
  logic signed [COORD_BITS-1:0] ax1, ay1;
  // stage 2: cross products
  logic signed [PROD_W-1:0] p_dd1, p_dd2, p_t1, p_t2, p_u1, p_u2;
  logic signed [DIFF_W-1:0] d1x2, d1y2;
  logic signed [COORD_BITS-1:0] ax2, ay2;
  // stage 3: raw den, tn, un
  logic signed [CROSS_W-1:0] den3, tn3, un3;
  logic signed [DIFF_W-1:0] d1x3, d1y3;
  logic signed [COORD_BITS-1:0] ax3, ay3;
  // stage 4: normalized to positive den
  logic signed [CROSS_W-1:0] den4, tn4, un4;
  logic signed [DIFF_W-1:0] d1x4, d1y4;
  logic signed [COORD_BITS-1:0] ax4, ay4;
  // stage 5: hit decision and magnitudes
  logic hit5, neg_x5, neg_y5;
  logic [CROSS_W-1:0] den5, mtn5;
  logic [DIFF_W-1:0] md1x5, md1y5;
  logic signed [COORD_BITS-1:0] ax5, ay5;
  // stage 6: products
  logic hit6, neg_x6, neg_y6;
  logic [CROSS_W-1:0] den6;
  logic [MUL_W-1:0] mx6, my6;
  logic signed [COORD_BITS-1:0] ax6, ay6;
  // stage 7: dividends
  logic hit7, neg_x7, neg_y7;
  logic [REM_W-1:0] dd7;
  logic [DVD_W-1:0] nx7, ny7;
  logic signed [COORD_BITS-1:0] ax7, ay7;
  // divider stages
  div_stage_t dv [QBITS+1];
  logic       dvv [QBITS+1];
  // stage 50: signed offsets
  logic hit50;
  logic signed [SUM_W-1:0] offx50, offy50;
  logic signed [COORD_BITS-1:0] ax50, ay50;

  logic signed [CROSS_W-1:0] den4_next, tn4_next, un4_next;
  logic hit5_next;
  logic [QBITS-1:0] offx_mag, offy_mag;
  logic signed [SUM_W-1:0] totx, toty;

  assign busy = 1'b0;

  // hold the mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      infinite_lines_mode <= 1'b0;
    end else if (cfg_we) begin
      infinite_lines_mode <= cfg_wdata;
    end
  end

  // advance the valid bits of the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5; v7 <= v6;
    end
  end

  // normalize the sign of den and decide the hit
  always_comb begin
    if (den3[CROSS_W-1]) begin
      den4_next = -den3;
      tn4_next  = -tn3;
      un4_next  = -un3;
    end else begin
      den4_next = den3;
      tn4_next  = tn3;
      un4_next  = un3;
    end
    hit5_next = (den4 != '0) &&
                (infinite_lines_mode ||
                 (!tn4[CROSS_W-1] && tn4 <= den4 && !un4[CROSS_W-1] && un4 <= den4));
  end

  // front payload stages
  always_ff @(posedge clk) begin
    d1x1 <= DIFF_W'(a_end_x) - DIFF_W'(a_start_x);
    d1y1 <= DIFF_W'(a_end_y) - DIFF_W'(a_start_y);
    d2x1 <= DIFF_W'(b_end_x) - DIFF_W'(b_start_x);
    d2y1 <= DIFF_W'(b_end_y) - DIFF_W'(b_start_y);
    wx1  <= DIFF_W'(b_start_x) - DIFF_W'(a_start_x);
    wy1  <= DIFF_W'(b_start_y) - DIFF_W'(a_start_y);
    ax1  <= a_start_x;
    ay1  <= a_start_y;

    p_dd1 <= PROD_W'(d1x1) * PROD_W'(d2y1);
    p_dd2 <= PROD_W'(d1y1) * PROD_W'(d2x1);
    p_t1  <= PROD_W'(wx1) * PROD_W'(d2y1);
    p_t2  <= PROD_W'(wy1) * PROD_W'(d2x1);
    p_u1  <= PROD_W'(wx1) * PROD_W'(d1y1);
    p_u2  <= PROD_W'(wy1) * PROD_W'(d1x1);
    d1x2 <= d1x1; d1y2 <= d1y1; ax2 <= ax1; ay2 <= ay1;

    den3 <= CROSS_W'(p_dd1) - CROSS_W'(p_dd2);
    tn3  <= CROSS_W'(p_t1) - CROSS_W'(p_t2);
    un3  <= CROSS_W'(p_u1) - CROSS_W'(p_u2);
    d1x3 <= d1x2; d1y3 <= d1y2; ax3 <= ax2; ay3 <= ay2;

    den4 <= den4_next; tn4 <= tn4_next; un4 <= un4_next;
    d1x4 <= d1x3; d1y4 <= d1y3; ax4 <= ax3; ay4 <= ay3;

    hit5   <= hit5_next;
    den5   <= den4;
    mtn5   <= tn4[CROSS_W-1] ? -tn4 : tn4;
    md1x5  <= d1x4[DIFF_W-1] ? -d1x4 : d1x4;
    md1y5  <= d1y4[DIFF_W-1] ? -d1y4 : d1y4;
    neg_x5 <= tn4[CROSS_W-1] ^ d1x4[DIFF_W-1];
    neg_y5 <= tn4[CROSS_W-1] ^ d1y4[DIFF_W-1];
    ax5 <= ax4; ay5 <= ay4;

    mx6  <= MUL_W'(mtn5) * MUL_W'(md1x5);
    my6  <= MUL_W'(mtn5) * MUL_W'(md1y5);
    hit6 <= hit5; neg_x6 <= neg_x5; neg_y6 <= neg_y5; den6 <= den5;
    ax6 <= ax5; ay6 <= ay5;

    // 2*m*65536 plus den, or den-1 for a negative offset
    nx7 <= (DVD_W'(mx6) << RND_SHIFT) + DVD_W'(neg_x6 ? den6 - 1'b1 : den6);
    ny7 <= (DVD_W'(my6) << RND_SHIFT) + DVD_W'(neg_y6 ? den6 - 1'b1 : den6);
    dd7 <= {den6, 1'b0};
    hit7 <= hit6; neg_x7 <= neg_x6; neg_y7 <= neg_y6;
    ax7 <= ax6; ay7 <= ay6;
  end

  // load the divider: flag quotients of 2^41 and above, seed the remainders
  always_ff @(posedge clk) begin
    dv[0].ovf_x <= (nx7 >> QBITS) >= DVD_W'(dd7);
    dv[0].ovf_y <= (ny7 >> QBITS) >= DVD_W'(dd7);
    dv[0].rem_x <= REM_W'(nx7 >> QBITS);
    dv[0].rem_y <= REM_W'(ny7 >> QBITS);
    dv[0].q_x   <= nx7[QBITS-1:0];
    dv[0].q_y   <= ny7[QBITS-1:0];
    dv[0].dd    <= dd7;
    dv[0].hit   <= hit7;
    dv[0].neg_x <= neg_x7;
    dv[0].neg_y <= neg_y7;
    dv[0].ax    <= ax7;
    dv[0].ay    <= ay7;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvv[0] <= 1'b0;
    end else begin
      dvv[0] <= v7;
    end
  end

  // one quotient bit per stage, both coordinates side by side
  for (genvar i = 0; i < QBITS; i++) begin : g_div
    logic [REM_W:0]   rs_x, rs_y;
    logic             ge_x, ge_y;
    div_stage_t       nxt;

    assign rs_x = {dv[i].rem_x, dv[i].q_x[QBITS-1]};
    assign rs_y = {dv[i].rem_y, dv[i].q_y[QBITS-1]};
    assign ge_x = rs_x >= {1'b0, dv[i].dd};
    assign ge_y = rs_y >= {1'b0, dv[i].dd};

    always_comb begin
      nxt       = dv[i];
      nxt.rem_x = ge_x ? REM_W'(rs_x - {1'b0, dv[i].dd}) : rs_x[REM_W-1:0];
      nxt.rem_y = ge_y ? REM_W'(rs_y - {1'b0, dv[i].dd}) : rs_y[REM_W-1:0];
      nxt.q_x   = {dv[i].q_x[QBITS-2:0], ge_x};
      nxt.q_y   = {dv[i].q_y[QBITS-2:0], ge_y};
    end

    always_ff @(posedge clk) begin
      dv[i+1] <= nxt;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[i+1] <= 1'b0;
      end else begin
        dvv[i+1] <= dvv[i];
      end
    end
  end

  // clamp and sign the offsets
  always_comb begin
    offx_mag = (dv[QBITS].ovf_x || dv[QBITS].q_x > OFF_LIM) ? OFF_LIM : dv[QBITS].q_x;
    offy_mag = (dv[QBITS].ovf_y || dv[QBITS].q_y > OFF_LIM) ? OFF_LIM : dv[QBITS].q_y;
  end

  always_ff @(posedge clk) begin
    offx50 <= dv[QBITS].neg_x ? -SUM_W'(offx_mag) : SUM_W'(offx_mag);
    offy50 <= dv[QBITS].neg_y ? -SUM_W'(offy_mag) : SUM_W'(offy_mag);
    hit50  <= dv[QBITS].hit;
    ax50   <= dv[QBITS].ax;
    ay50   <= dv[QBITS].ay;
  end

  // add the start point and saturate to Q16.16
  assign totx = (SUM_W'(ax50) <<< FRAC_BITS) + offx50;
  assign toty = (SUM_W'(ay50) <<< FRAC_BITS) + offy50;

  always_ff @(posedge clk) begin
    if (rst) begin
      v50  <= 1'b0;
      done <= 1'b0;
    end else begin
      v50  <= dvv[QBITS];
      done <= v50;
    end
  end

  always_ff @(posedge clk) begin
    hit <= hit50;
    if (!hit50) begin
      inter_x <= '0;
      inter_y <= '0;
    end else begin
      inter_x <= (totx > OUT_MAX) ? OUT_W'(OUT_MAX) :
                 (totx < OUT_MIN) ? OUT_W'(OUT_MIN) : OUT_W'(totx);
      inter_y <= (toty > OUT_MAX) ? OUT_W'(OUT_MAX) :
                 (toty < OUT_MIN) ? OUT_W'(OUT_MIN) : OUT_W'(toty);
    end
  end

  // checks
  `ASSERT_CLK(a_nohit_zero, done && !hit |-> inter_x == 0 && inter_y == 0, "miss with nonzero point")
  `ASSERT_CLK(a_par_nohit, v4 && den4 == 0 |-> !hit5_next, "parallel pair flagged as hit")
  `ASSERT_NEXT(a_div_to_out, dvv[QBITS], ##1 done, "divider result lost before output")
  `ASSERT_CLK(a_seg_bound, v5 && hit5 && !infinite_lines_mode |-> mtn5 <= den5, "t outside range")

endmodule

[verif/segment_intersection_top_tb.sv]
// Self-checking testbench for the pipelined two-segment intersection block.
`timescale 1ns / 1ps

module segment_intersection_top_tb;
  import segi_pkg::*;

  localparam int LATENCY = 51;
  localparam longint OFFSET_LIM = 64'sd1 << 40;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    logic            hit;
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
  } meet_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  coord_t a_start_x = '0, a_start_y = '0, a_end_x = '0, a_end_y = '0;
  coord_t b_start_x = '0, b_start_y = '0, b_end_x = '0, b_end_y = '0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic done;
  logic hit;
  logic signed [OUT_W-1:0] inter_x;
  logic signed [OUT_W-1:0] inter_y;

  meet_t meet_q[$];
  logic  lines_mode = 1'b0;
  bit    quiet = 1'b0;
  int    errors = 0;

  segment_intersection_top i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .a_start_x(a_start_x), .a_start_y(a_start_y), .a_end_x(a_end_x), .a_end_y(a_end_y),
    .b_start_x(b_start_x), .b_start_y(b_start_y), .b_end_x(b_end_x), .b_end_y(b_end_y),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .done(done), .hit(hit), .inter_x(inter_x), .inter_y(inter_y)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hold a hard limit on the run
  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  // Round start*65536 + t*dc*65536 to nearest, ties up, then saturate to Q16.16
  function automatic logic [OUT_W-1:0] meet_coord(longint s, longint tn, longint dc,
                                                  longint den);
    logic [127:0] prod, num, quo;
    logic         neg;
    longint       off, tot;
    neg  = (tn < 0) != (dc < 0);
    prod = 128'(tn < 0 ? -tn : tn) * 128'(dc < 0 ? -dc : dc);
    num  = (prod << 17) + 128'(neg ? den - 1 : den);
    quo  = num / 128'(2 * den);
    if (quo > 128'(OFFSET_LIM)) off = neg ? -OFFSET_LIM : OFFSET_LIM;
    else off = neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
    tot = s * 65536 + off;
    if (tot > 64'sh7FFF_FFFF) tot = 64'sh7FFF_FFFF;
    if (tot < -64'sh8000_0000) tot = -64'sh8000_0000;
    return tot[OUT_W-1:0];
  endfunction

  function automatic meet_t predict_meet(coord_t ax0, coord_t ay0, coord_t ax1, coord_t ay1,
                                         coord_t bx0, coord_t by0, coord_t bx1, coord_t by1);
    meet_t  r;
    longint d1x, d1y, d2x, d2y, wx, wy, den, tn, un;
    d1x = longint'(ax1) - ax0;  d1y = longint'(ay1) - ay0;
    d2x = longint'(bx1) - bx0;  d2y = longint'(by1) - by0;
    wx  = longint'(bx0) - ax0;  wy  = longint'(by0) - ay0;
    den = d1x * d2y - d1y * d2x;
    tn  = wx * d2y - wy * d2x;
    un  = wx * d1y - wy * d1x;
    r = '{1'b0, '0, '0};
    if (den < 0) begin
      den = -den; tn = -tn; un = -un;
    end
    if (den == 0) return r;
    if (!lines_mode && (tn < 0 || tn > den || un < 0 || un > den)) return r;
    r.hit = 1'b1;
    r.x = meet_coord(ax0, tn, d1x, den);
    r.y = meet_coord(ay0, tn, d1y, den);
    return r;
  endfunction

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (meet_q.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
      end else begin
        meet_t e;
        e = meet_q.pop_front();
        if (hit !== e.hit) begin
          $error("hit: expected %0d, actual %0d", e.hit, hit);
          errors++;
        end
        if (inter_x !== e.x) begin
          $error("inter_x: expected %h, actual %h", e.x, inter_x);
          errors++;
        end
        if (inter_y !== e.y) begin
          $error("inter_y: expected %h, actual %h", e.y, inter_y);
          errors++;
        end
      end
    end
  end

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drive one pair and hold it until the transfer, then maybe pause
  task automatic send_pair(coord_t ax0, coord_t ay0, coord_t ax1, coord_t ay1,
                           coord_t bx0, coord_t by0, coord_t bx1, coord_t by1);
    start <= 1'b1;
    a_start_x <= ax0; a_start_y <= ay0; a_end_x <= ax1; a_end_y <= ay1;
    b_start_x <= bx0; b_start_y <= by0; b_end_x <= bx1; b_end_y <= by1;
    do @(posedge clk); while (busy);
    meet_q.push_back(predict_meet(ax0, ay0, ax1, ay1, bx0, by0, bx1, by1));
    if (!quiet && $urandom_range(3) == 0) idle_cycles($urandom_range(4, 1));
  endtask

  task automatic drain();
    idle_cycles(1);
    while (meet_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    lines_mode = m;
  endtask

  function automatic coord_t rand_coord(int kind);
    case (kind)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(16)) - 8);
      default: return $urandom_range(1) ? coord_t'(16'sh7FFF) : coord_t'(16'sh8000);
    endcase
  endfunction

  // Build two segments that cross near a random point, or arbitrary ones
  task automatic send_random();
    int     sel, px, py, d1x, d1y, d2x, d2y, k;
    coord_t c[8];
    sel = $urandom_range(9);
    if (sel < 5) begin
      k   = (sel < 2) ? 8 : 8000;
      px  = $signed($urandom_range(32000)) - 16000;
      py  = $signed($urandom_range(32000)) - 16000;
      d1x = $signed($urandom_range(2 * k)) - k;  d1y = $signed($urandom_range(2 * k)) - k;
      d2x = $signed($urandom_range(2 * k)) - k;  d2y = $signed($urandom_range(2 * k)) - k;
      c = '{coord_t'(px - d1x), coord_t'(py - d1y), coord_t'(px + d1x), coord_t'(py + d1y),
            coord_t'(px - d2x), coord_t'(py - d2y), coord_t'(px + d2x), coord_t'(py + d2y)};
    end else begin
      k = (sel < 8) ? 0 : ((sel == 8) ? 1 : 2);
      foreach (c[i]) c[i] = rand_coord($urandom_range(3) == 0 ? $urandom_range(2) : k);
    end
    send_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
  endtask

  task automatic test_segment_cases();
    send_pair(0, 0, 10, 10, 0, 10, 10, 0);           // plain crossing
    send_pair(0, 0, 10, 0, 0, 5, 10, 5);             // parallel
    send_pair(0, 0, 10, 0, 2, 0, 8, 0);              // collinear
    send_pair(3, 3, 3, 3, 0, 0, 5, 5);               // zero-length segment
    send_pair(0, 0, 10, 0, 10, -5, 10, 5);           // touch at end, t = 1
    send_pair(0, 0, 10, 0, 0, -5, 0, 5);             // touch at start, t = 0
    send_pair(0, 0, 10, 0, 11, -5, 11, 5);           // vertical just outside
    send_pair(5, -5, 5, 5, 0, 6, 10, 6);             // horizontal just outside
    send_pair(0, 0, 3, 0, 1, -1, 2, 2);              // fractional point, rounding
    send_pair(0, 0, 1, 1, 0, 1, 1, 0);               // half-unit point
    send_pair(0, 0, -3, 0, -1, 1, -2, -2);           // negative offset rounding
    send_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    send_pair(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767);
    send_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
  endtask

  task automatic test_line_cases();
    send_pair(0, 0, 1, 0, 5, 3, 5, 4);               // meet beyond both segments
    send_pair(0, 0, 10, 0, 0, 5, 10, 5);             // parallel still misses
    send_pair(0, 0, 32767, 1, 0, 1, 32767, 3);       // meet behind both starts, t = -1
    send_pair(0, 0, -32768, 1, 0, -1, -32768, 1);    // negative far point
    send_pair(-32768, -32768, -32767, -32768, 32767, 32767, 32766, 32767);
    send_pair(32767, -32768, -32768, 32767, 0, 0, 1, 1);
    send_pair(0, 0, 3, 0, 1, -1, 2, 2);
  endtask

  task automatic test_random(int n, logic m);
    write_mode(m);
    repeat (n) send_random();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_segment_cases();
    write_mode(1'b1);
    test_line_cases();
    write_mode(1'b0);
    test_segment_cases();
    test_random(700, 1'b0);
    test_random(600, 1'b1);
    test_random(200, 1'b0);
    quiet = 1'b1;
    test_random(200, 1'b1);
    drain();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
